// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros for the frame extractor checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define HLFE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hlfe assertion failed");

// consequent must hold in the same cycle as the antecedent
`define HLFE_ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hlfe implication failed");

// consequent must hold in the cycle after the antecedent
`define HLFE_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hlfe next-cycle implication failed");

`endif

// ===== hw/rtl/hlfe_pkg.sv =====
package hlfe_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 9;
  localparam int unsigned FillW   = 3;
  localparam int unsigned WindowW = 4 * ByteW;
  localparam int unsigned CfgIdxW = 2;

  // header occupies positions 0 to 4, window holds the four bytes before the last
  localparam logic [FillW-1:0] FillFull   = 3'd4;
  localparam logic [PosW-1:0]  PosHdrLast = 9'd4;
  localparam logic [PosW-1:0]  PosLength  = 9'd5;
  localparam logic [PosW-1:0]  PosUnit    = 9'd6;
  localparam logic [PosW-1:0]  PosFunc    = 9'd7;
  localparam logic [PosW-1:0]  PosPayFirst = 9'd9;
  localparam logic [PosW-1:0]  PosPayLast  = 9'd40; // 9 + 32 - 1

  localparam logic [ByteW-1:0] RespUnit = 8'h01;
  localparam logic [ByteW-1:0] RespFunc = 8'h03;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_FOURTH = 2'd1,
    CFG_SYNC_FIFTH  = 2'd2
  } cfg_idx_e;

endpackage

// ===== hw/rtl/header_length_frame_extractor.sv =====
// an accepted in-frame byte is registered into the output register with its position and flags
// throughput: 1 byte per cycle while in_stall_o is low; header compare and length update are combinational
// hunting bytes and the header's last byte give no result
// in_stall_o is high only while a result waits and out_stall_i is high
// reset (rst_ni low, asynchronous) clears sync registers, hunt state and output valid
module header_length_frame_extractor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hlfe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hlfe_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hlfe_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hlfe_pkg::ByteW-1:0]   frame_byte_o,
  output logic [hlfe_pkg::PosW-1:0]    frame_pos_o,
  output logic                         end_of_frame_o,
  output logic                         read_response_o,
  output logic                         forward_payload_o
);
  import hlfe_pkg::*;

  logic [ByteW-1:0]   sync_first_q, sync_fourth_q, sync_fifth_q;
  logic [WindowW-1:0] window_q, window_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               in_frame_q, in_frame_d;
  logic [ByteW-1:0]   left_q, left_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               unit_q, unit_d;
  logic               resp_q, resp_d;

  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   byte_q;
  logic [PosW-1:0]    opos_q;
  logic               eof_q, oresp_q, fwd_q;

  logic               accept;
  logic               hdr_hit;
  logic [PosW-1:0]    pos_next;
  logic [ByteW-1:0]   left_dec;
  logic               last;
  logic               emit;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_fourth_q <= '0;
      sync_fifth_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_FOURTH: sync_fourth_q <= cfg_data_i;
        CFG_SYNC_FIFTH:  sync_fifth_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign hdr_hit = (fill_q == FillFull) &&
                   (window_q[31:24] == sync_first_q) &&
                   (window_q[23:16] == sync_first_q) &&
                   (window_q[15:8]  == sync_first_q) &&
                   (window_q[7:0]   == sync_fourth_q) &&
                   (rx_byte_i == sync_fifth_q);

  assign pos_next = pos_q + 9'd1;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    window_d   = window_q;
    fill_d     = fill_q;
    in_frame_d = in_frame_q;
    left_d     = left_q;
    pos_d      = pos_q;
    unit_d     = unit_q;
    resp_d     = resp_q;
    last       = 1'b0;
    emit       = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (hdr_hit) begin
          in_frame_d = 1'b1;
          pos_d      = PosHdrLast;
          left_d     = '0;
          unit_d     = 1'b0;
          resp_d     = 1'b0;
        end else begin
          window_d = {window_q[WindowW-ByteW-1:0], rx_byte_i};
          if (fill_q != FillFull) fill_d = fill_q + 3'd1;
        end
      end else begin
        emit  = 1'b1;
        pos_d = pos_next;
        if (pos_next == PosLength) begin
          left_d = rx_byte_i;
          last   = (rx_byte_i == '0);
        end else begin
          left_d = left_dec;
          last   = (left_dec == '0);
        end
        if (pos_next == PosUnit) unit_d = (rx_byte_i == RespUnit);
        if (pos_next == PosFunc) resp_d = unit_q && (rx_byte_i == RespFunc);
        // frame done: back to hunting with an empty window
        if (last) begin
          window_d   = '0;
          fill_d     = '0;
          in_frame_d = 1'b0;
          left_d     = '0;
          pos_d      = '0;
          unit_d     = 1'b0;
          resp_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      fill_q     <= '0;
      in_frame_q <= 1'b0;
      left_q     <= '0;
      pos_q      <= '0;
      unit_q     <= 1'b0;
      resp_q     <= 1'b0;
    end else begin
      window_q   <= window_d;
      fill_q     <= fill_d;
      in_frame_q <= in_frame_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      unit_q     <= unit_d;
      resp_q     <= resp_d;
    end
  end

  // output register: loads on an emitting transaction, drains when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q  <= rx_byte_i;
      opos_q  <= pos_next;
      eof_q   <= last;
      oresp_q <= (pos_next == PosFunc) ? (unit_q && (rx_byte_i == RespFunc)) : resp_q;
      fwd_q   <= ((pos_next == PosFunc) ? (unit_q && (rx_byte_i == RespFunc)) : resp_q) &&
                 (pos_next >= PosPayFirst) && (pos_next <= PosPayLast);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_byte_o      = byte_q;
  assign frame_pos_o       = opos_q;
  assign end_of_frame_o    = eof_q;
  assign read_response_o   = oresp_q;
  assign forward_payload_o = fwd_q;

endmodule

// ===== hw/rtl/hlfe_checker.sv =====
`include "assert_macros.svh"

module hlfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic [8:0] frame_pos_o,
  input logic       end_of_frame_o,
  input logic       read_response_o,
  input logic       forward_payload_o
);

  // a stalled result transaction holds
  `HLFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(frame_byte_o) && $stable(frame_pos_o) && $stable(end_of_frame_o))

  // positions start at the length byte and never pass the longest frame
  `HLFE_ASSERT_IMPL(a_pos_range, clk_i, rst_ni, out_valid_o, frame_pos_o >= 9'd5 && frame_pos_o <= 9'd260)

  // payload marking only inside a read response, positions 9 to 40
  `HLFE_ASSERT_IMPL(a_fwd_window, clk_i, rst_ni, out_valid_o && forward_payload_o, read_response_o && frame_pos_o >= 9'd9 && frame_pos_o <= 9'd40)

  // read response is known only from the function byte on
  `HLFE_ASSERT_IMPL(a_resp_late, clk_i, rst_ni, out_valid_o && read_response_o, frame_pos_o >= 9'd7)

  // a frame ending at the length byte has zero length
  `HLFE_ASSERT(a_zero_len, clk_i, rst_ni, !(out_valid_o && end_of_frame_o && frame_pos_o == 9'd5) || frame_byte_o == 8'd0)

endmodule

bind header_length_frame_extractor hlfe_checker u_hlfe_checker (.*);
